// File: hdl/rc_channel_normalizer_unit_assert.svh
// ----------------------------------------------------------------------------
// rc_channel_normalizer_unit_assert.svh
// Assertion macros shared by the normalizer RTL. Each expects clk and rst in
// scope and is switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef RC_CHANNEL_NORMALIZER_UNIT_ASSERT_SVH
`define RC_CHANNEL_NORMALIZER_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RCN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define RCN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rcn_pkg.sv
// ----------------------------------------------------------------------------
// rcn_pkg
// Shared constants and types of the receiver channel normalizer.
// ----------------------------------------------------------------------------
package rcn_pkg;

  // Q2.14 levels
  localparam int Q_FRAC  = 14;
  localparam int Q_ONE   = 1 << Q_FRAC;
  localparam int LEVEL_W = 16;
  localparam int THR_W   = 15;
  localparam int MODE_W  = 3;
  localparam int DZ_W    = 10;

  localparam int NUM_AXES = 3;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // pipelined divider: quotient bits, bits per stage, stage count
  localparam int QBITS        = 15;
  localparam int DIV_STEPS    = 3;
  localparam int DIV_STAGES   = QBITS / DIV_STEPS;
  localparam int LANE_LATENCY = DIV_STAGES + 2;
  localparam int LATENCY      = LANE_LATENCY + 1;

  // x / 5 as (x * RECIP5) >> RECIP5_SHIFT, exact for x below 2^16
  localparam int RECIP5       = 52429;
  localparam int RECIP5_W     = 16;
  localparam int RECIP5_SHIFT = 18;

  localparam int MODE_MAX    = 5;
  localparam int MIN_SPACING = 5;

  // register reset values
  localparam int RST_PULSE_MIN    = 1100;
  localparam int RST_PULSE_CENTER = 1500;
  localparam int RST_PULSE_MAX    = 1900;
  localparam int RST_DEAD_ZONE    = 0;
  localparam int RST_ARM_LOW      = 1600;
  localparam int RST_ARM_HIGH     = 2500;
  localparam int RST_MODE_LOW     = 1165;
  localparam int RST_MODE_HIGH    = 1815;
  localparam int ARM_RST_W        = 12;

  typedef enum logic [2:0] {
    REG_PULSE_MIN    = 3'd0,
    REG_PULSE_CENTER = 3'd1,
    REG_PULSE_MAX    = 3'd2,
    REG_DEAD_ZONE    = 3'd3,
    REG_ARM_LOW      = 3'd4,
    REG_ARM_HIGH     = 3'd5,
    REG_MODE_LOW     = 3'd6,
    REG_MODE_HIGH    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic neg;   // apply negative sign after rounding
    logic zero;  // level forced to zero
    logic full;  // |num| >= den, level saturates
  } lane_flags_t;

  typedef struct packed {
    logic        valid;
    lane_flags_t flags;
  } lane_ctrl_t;

  typedef struct packed {
    logic              link_ok;
    logic              armed;
    logic [MODE_W-1:0] mode;
  } switch_res_t;

endpackage

// File: hdl/rc_channel_normalizer_unit.sv
// ----------------------------------------------------------------------------
// rc_channel_normalizer_unit
// Receiver frame to normalised throttle, roll, pitch, yaw, arm and mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input: pulse a frame in with start; it is taken at any edge where start
//   is high and busy is low. busy stays low, so a frame may follow every
//   cycle.
//   Output: done is high for one cycle with the result on the level ports.
//   The result passes the input register, the divider stages and the divider
//   output register. One result per frame, in order.
//   Throughput is one frame per clock: each axis has its own divider with
//   a 15-bit quotient retired 3 bits per stage over 5 stages.
//   The receiver has no back-pressure; a result is shown for one cycle only.
//   Link down gives an all-zero result, link_ok included.
//   Configuration sits on the APB port, one register per word. Write it only
//   while no frame is in flight.
//   Reset: rst (synchronous) empties the pipeline and loads the default
//   stick calibration into the registers.
// ----------------------------------------------------------------------------
`include "rc_channel_normalizer_unit_assert.svh"

module rc_channel_normalizer_unit #(
  parameter int PULSE_BITS = 12
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     link_up,
  input  logic [PULSE_BITS-1:0]                    throttle_pulse,
  input  logic [PULSE_BITS-1:0]                    roll_pulse,
  input  logic [PULSE_BITS-1:0]                    pitch_pulse,
  input  logic [PULSE_BITS-1:0]                    yaw_pulse,
  input  logic [PULSE_BITS-1:0]                    arm_pulse,
  input  logic [PULSE_BITS-1:0]                    mode_pulse,
  output logic                                     done,
  output logic                                     link_ok,
  output logic [rcn_pkg::THR_W-1:0]                throttle_level,
  output logic signed [rcn_pkg::LEVEL_W-1:0]       roll_level,
  output logic signed [rcn_pkg::LEVEL_W-1:0]       pitch_level,
  output logic signed [rcn_pkg::LEVEL_W-1:0]       yaw_level,
  output logic                                     armed,
  output logic [rcn_pkg::MODE_W-1:0]               flight_mode,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [rcn_pkg::CFG_ADDR_W-1:0]           paddr,
  input  logic [rcn_pkg::CFG_DATA_W-1:0]           pwdata,
  output logic [rcn_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                     pready
);
  import rcn_pkg::*;

  localparam int PB    = PULSE_BITS;
  localparam int ARM_W = (PB > ARM_RST_W) ? PB : ARM_RST_W;
  localparam int SW    = PB + 2;

  // configuration registers
  logic [PB-1:0]    pulse_min, pulse_center, pulse_max;
  logic [DZ_W-1:0]  dead_zone;
  logic [PB-1:0]    arm_low;
  logic [ARM_W-1:0] arm_high;
  logic [PB-1:0]    mode_low, mode_high;

  logic       cfg_we;
  reg_index_t cfg_idx;

  // input stage
  logic          accept;
  logic          in_v, in_link;
  logic [PB-1:0] in_thr, in_arm, in_mode;
  logic [PB-1:0] in_axis [NUM_AXES];

  // prep
  logic signed [SW-1:0] min_s, ctr_s, max_s, dz_s;
  logic signed [SW-1:0] lo_edge, hi_edge;
  logic signed [SW-1:0] thr_low, thr_den, thr_num;

  lane_ctrl_t    thr_ctrl;
  logic [PB-1:0] thr_mag, thr_dv;
  lane_ctrl_t    ax_ctrl [NUM_AXES];
  logic [PB-1:0] ax_mag  [NUM_AXES];
  logic [PB-1:0] ax_dv   [NUM_AXES];

  // lane outputs
  logic                      thr_valid;
  logic signed [LEVEL_W-1:0] thr_level;
  logic                      ax_valid [NUM_AXES];
  logic signed [LEVEL_W-1:0] ax_level [NUM_AXES];
  logic                      sw_valid;
  switch_res_t               sw_res;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_index_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min    <= PB'(RST_PULSE_MIN);
      pulse_center <= PB'(RST_PULSE_CENTER);
      pulse_max    <= PB'(RST_PULSE_MAX);
      dead_zone    <= DZ_W'(RST_DEAD_ZONE);
      arm_low      <= PB'(RST_ARM_LOW);
      arm_high     <= ARM_W'(RST_ARM_HIGH);
      mode_low     <= PB'(RST_MODE_LOW);
      mode_high    <= PB'(RST_MODE_HIGH);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PULSE_MIN:    pulse_min    <= pwdata[PB-1:0];
        REG_PULSE_CENTER: pulse_center <= pwdata[PB-1:0];
        REG_PULSE_MAX:    pulse_max    <= pwdata[PB-1:0];
        REG_DEAD_ZONE:    dead_zone    <= pwdata[DZ_W-1:0];
        REG_ARM_LOW:      arm_low      <= pwdata[PB-1:0];
        REG_ARM_HIGH:     arm_high     <= ARM_W'(pwdata[PB-1:0]);
        REG_MODE_LOW:     mode_low     <= pwdata[PB-1:0];
        REG_MODE_HIGH:    mode_high    <= pwdata[PB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PULSE_MIN:    prdata = CFG_DATA_W'(pulse_min);
      REG_PULSE_CENTER: prdata = CFG_DATA_W'(pulse_center);
      REG_PULSE_MAX:    prdata = CFG_DATA_W'(pulse_max);
      REG_DEAD_ZONE:    prdata = CFG_DATA_W'(dead_zone);
      REG_ARM_LOW:      prdata = CFG_DATA_W'(arm_low);
      REG_ARM_HIGH:     prdata = CFG_DATA_W'(arm_high);
      REG_MODE_LOW:     prdata = CFG_DATA_W'(mode_low);
      REG_MODE_HIGH:    prdata = CFG_DATA_W'(mode_high);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- input stage
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_link    <= link_up;
      in_thr     <= throttle_pulse;
      in_axis[0] <= roll_pulse;
      in_axis[1] <= pitch_pulse;
      in_axis[2] <= yaw_pulse;
      in_arm     <= arm_pulse;
      in_mode    <= mode_pulse;
    end
  end

  // ---------------------------------------------------------------- prep
  always_comb begin
    min_s   = SW'(pulse_min);
    ctr_s   = SW'(pulse_center);
    max_s   = SW'(pulse_max);
    dz_s    = SW'(dead_zone);
    lo_edge = ctr_s - dz_s;
    hi_edge = ctr_s + dz_s;

    thr_low = min_s + dz_s;
    thr_den = max_s - thr_low;
    thr_num = SW'(in_thr) - thr_low;

    thr_ctrl.valid      = in_v;
    thr_ctrl.flags.neg  = 1'b0;
    thr_ctrl.flags.zero = !in_link || thr_den <= 0 || thr_num <= 0;
    thr_ctrl.flags.full = thr_num >= thr_den;
    thr_mag             = thr_num[PB-1:0];
    thr_dv              = thr_den[PB-1:0];
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic signed [SW-1:0] p_s, num, dv;
    logic                 neg, out_of_band;

    // each side of the deadband has its own span
    always_comb begin
      p_s = SW'(in_axis[a]);
      if (p_s < lo_edge) begin
        neg         = 1'b1;
        out_of_band = 1'b1;
        num         = lo_edge - p_s;
        dv          = lo_edge - min_s;
      end else if (p_s <= hi_edge) begin
        neg         = 1'b0;
        out_of_band = 1'b0;
        num         = '0;
        dv          = '0;
      end else begin
        neg         = 1'b0;
        out_of_band = 1'b1;
        num         = p_s - hi_edge;
        dv          = max_s - hi_edge;
      end
      ax_ctrl[a].valid      = in_v;
      ax_ctrl[a].flags.neg  = neg;
      ax_ctrl[a].flags.zero = !in_link || !out_of_band || dv <= 0;
      ax_ctrl[a].flags.full = num >= dv;
      ax_mag[a]             = num[PB-1:0];
      ax_dv[a]              = dv[PB-1:0];
    end

    rcn_qdiv #(
      .PULSE_BITS (PULSE_BITS)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ax_ctrl[a]),
      .mag       (ax_mag[a]),
      .den       (ax_dv[a]),
      .out_valid (ax_valid[a]),
      .level     (ax_level[a])
    );
  end

  rcn_qdiv #(
    .PULSE_BITS (PULSE_BITS)
  ) u_thr_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (thr_ctrl),
    .mag       (thr_mag),
    .den       (thr_dv),
    .out_valid (thr_valid),
    .level     (thr_level)
  );

  rcn_switch #(
    .PULSE_BITS (PULSE_BITS)
  ) u_switch (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_v),
    .link       (in_link),
    .arm_pulse  (in_arm),
    .mode_pulse (in_mode),
    .arm_low    (arm_low),
    .arm_high   (arm_high),
    .mode_low   (mode_low),
    .mode_high  (mode_high),
    .out_valid  (sw_valid),
    .res        (sw_res)
  );

  // -------------------------------------------------------------- result
  assign done           = sw_valid;
  assign link_ok        = sw_res.link_ok;
  assign armed          = sw_res.armed;
  assign flight_mode    = sw_res.mode;
  assign throttle_level = thr_level[THR_W-1:0];
  assign roll_level     = ax_level[0];
  assign pitch_level    = ax_level[1];
  assign yaw_level      = ax_level[2];

  `RCN_ASSERT_NOW(a_lanes_aligned, done,
    thr_valid && ax_valid[0] && ax_valid[1] && ax_valid[2],
    "lane valid missing when result is out")
  `RCN_ASSERT_NOW(a_lanes_quiet, !done,
    !thr_valid && !ax_valid[0] && !ax_valid[1] && !ax_valid[2],
    "lane valid without a result")
  `RCN_ASSERT_NOW(a_latency, done, $past(start && !busy, LATENCY),
    "result without an item accepted at the pipeline depth")
  `RCN_ASSERT_NOW(a_link_down_zero, done && !link_ok,
    thr_level == 0 && roll_level == 0 && pitch_level == 0 && yaw_level == 0 &&
    !armed && flight_mode == 0,
    "non-zero result with link down")
  `RCN_ASSERT_NOW(a_throttle_range, done,
    !thr_level[LEVEL_W-1] && flight_mode <= MODE_MAX,
    "throttle negative or mode out of range")

endmodule

// File: hdl/rcn_qdiv.sv
// ----------------------------------------------------------------------------
// rcn_qdiv
// Pipelined rounding divider: |num| * 2^14 / den in Q2.14, sign and
// saturation applied in the last stage. Takes one item per cycle.
// ----------------------------------------------------------------------------
`include "rc_channel_normalizer_unit_assert.svh"

module rcn_qdiv #(
  parameter int PULSE_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rcn_pkg::lane_ctrl_t                   ctrl,
  input  logic [PULSE_BITS-1:0]                 mag,
  input  logic [PULSE_BITS-1:0]                 den,
  output logic                                  out_valid,
  output logic signed [rcn_pkg::LEVEL_W-1:0]    level
);
  import rcn_pkg::*;

  localparam int PB = PULSE_BITS;
  localparam int NW = PB + QBITS;  // rounded dividend
  localparam int RW = PB + 1;      // trial remainder

  logic [NW-1:0] dividend;

  logic              st_valid [DIV_STAGES+1];
  lane_flags_t       st_flags [DIV_STAGES+1];
  logic [PB-1:0]     st_den   [DIV_STAGES+1];
  logic [PB-1:0]     st_rem   [DIV_STAGES+1];
  logic [QBITS-1:0]  st_low   [DIV_STAGES+1];
  logic [QBITS-1:0]  st_quo   [DIV_STAGES+1];

  logic [LEVEL_W-1:0]       mag_sat;
  logic signed [LEVEL_W-1:0] level_next;

  // mag * 2^14 + den/2; upper bits are below den whenever mag < den
  assign dividend = {1'b0, mag, {Q_FRAC{1'b0}}} + NW'(den >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else begin
      st_valid[0] <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    st_flags[0] <= ctrl.flags;
    st_den[0]   <= den;
    st_rem[0]   <= dividend[NW-1:QBITS];
    st_low[0]   <= dividend[QBITS-1:0];
    st_quo[0]   <= '0;
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [PB-1:0]    rem_n;
    logic [QBITS-1:0] low_n;
    logic [QBITS-1:0] quo_n;

    always_comb begin : c_step
      logic [RW-1:0]    trial;
      logic [PB-1:0]    r;
      logic [QBITS-1:0] lo;
      logic [QBITS-1:0] qu;
      r  = st_rem[s];
      lo = st_low[s];
      qu = st_quo[s];
      trial = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {r, lo[QBITS-1]};
        lo    = {lo[QBITS-2:0], 1'b0};
        if (trial >= {1'b0, st_den[s]}) begin
          trial = trial - {1'b0, st_den[s]};
          qu    = {qu[QBITS-2:0], 1'b1};
        end else begin
          qu    = {qu[QBITS-2:0], 1'b0};
        end
        r = trial[PB-1:0];
      end
      rem_n = r;
      low_n = lo;
      quo_n = qu;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s+1] <= 1'b0;
      end else begin
        st_valid[s+1] <= st_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      st_flags[s+1] <= st_flags[s];
      st_den[s+1]   <= st_den[s];
      st_rem[s+1]   <= rem_n;
      st_low[s+1]   <= low_n;
      st_quo[s+1]   <= quo_n;
    end
  end

  always_comb begin
    if (st_flags[DIV_STAGES].zero) begin
      mag_sat = '0;
    end else if (st_flags[DIV_STAGES].full ||
                 {1'b0, st_quo[DIV_STAGES]} > LEVEL_W'(Q_ONE)) begin
      mag_sat = LEVEL_W'(Q_ONE);
    end else begin
      mag_sat = {1'b0, st_quo[DIV_STAGES]};
    end
    level_next = st_flags[DIV_STAGES].neg ? -$signed(mag_sat) : $signed(mag_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= st_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    level <= level_next;
  end

  `RCN_ASSERT_NOW(a_level_range, out_valid, level >= -Q_ONE && level <= Q_ONE,
    "divider level outside -1..1")
  `RCN_ASSERT_NOW(a_valid_latency, out_valid, $past(ctrl.valid, LANE_LATENCY),
    "divider result without an item in")
  `RCN_ASSERT_NOW(a_zero_forced, out_valid && level != 0,
    $past(ctrl.valid && !ctrl.flags.zero, LANE_LATENCY),
    "non-zero level from an item marked zero")
  `RCN_ASSERT_NOW(a_sign, out_valid && level < 0, $past(ctrl.flags.neg, LANE_LATENCY),
    "negative level from a positive item")

endmodule

// File: hdl/rcn_switch.sv
// ----------------------------------------------------------------------------
// rcn_switch
// Arm window and mode switch quantiser, pipelined and delayed to line up
// with the divider lanes.
// ----------------------------------------------------------------------------
module rcn_switch #(
  parameter int PULSE_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     link,
  input  logic [PULSE_BITS-1:0]    arm_pulse,
  input  logic [PULSE_BITS-1:0]    mode_pulse,
  input  logic [PULSE_BITS-1:0]    arm_low,
  input  logic [((PULSE_BITS > rcn_pkg::ARM_RST_W) ? PULSE_BITS
                 : rcn_pkg::ARM_RST_W)-1:0] arm_high,
  input  logic [PULSE_BITS-1:0]    mode_low,
  input  logic [PULSE_BITS-1:0]    mode_high,
  output logic                     out_valid,
  output rcn_pkg::switch_res_t     res
);
  import rcn_pkg::*;

  localparam int PB    = PULSE_BITS;
  localparam int ARM_W = (PB > ARM_RST_W) ? PB : ARM_RST_W;
  localparam int DW    = PB + 1;              // signed difference
  localparam int PW    = PB + RECIP5_W;       // reciprocal product
  localparam int SPW   = PB - 2;              // spacing, below 2^PB / 5
  localparam int TW    = PB + 2;              // signed rounded offset
  localparam int MW    = PB + 1;              // spacing multiples
  localparam int EXTRA = LANE_LATENCY - 4;

  // stage 1
  logic                 v1, link1, arm1;
  logic signed [DW-1:0] diff1, tp1;
  // stage 2
  logic                 v2, link2, arm2, dneg2;
  logic [PW-1:0]        prod2;
  logic signed [DW-1:0] tp2;
  // stage 3
  logic                 v3, link3, arm3, ok3;
  logic [SPW-1:0]       spacing3;
  logic signed [TW-1:0] t3;
  // stage 4
  logic                 v4;
  switch_res_t          res4;
  switch_res_t          res4_next;

  logic [SPW-1:0]       spacing2;
  logic [MW-1:0]        s1, s2, s3, s4, s5;
  logic [MW-1:0]        t_u;

  logic                 dl_valid [EXTRA+1];
  switch_res_t          dl_res   [EXTRA+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign spacing2 = prod2[RECIP5_SHIFT +: SPW];

  always_ff @(posedge clk) begin
    link1 <= link;
    arm1  <= (ARM_W'(arm_pulse) >= ARM_W'(arm_low)) && (ARM_W'(arm_pulse) < arm_high);
    diff1 <= $signed({1'b0, mode_high}) - $signed({1'b0, mode_low});
    tp1   <= $signed({1'b0, mode_pulse}) - $signed({1'b0, mode_low});

    link2 <= link1;
    arm2  <= arm1;
    dneg2 <= diff1[DW-1];
    prod2 <= PW'(diff1[PB-1:0]) * PW'(RECIP5);
    tp2   <= tp1;

    link3    <= link2;
    arm3     <= arm2;
    ok3      <= !dneg2 && (spacing2 >= SPW'(MIN_SPACING));
    spacing3 <= spacing2;
    t3       <= TW'(tp2) + $signed(TW'(spacing2 >> 1));

    res4 <= res4_next;
  end

  // position = number of spacing multiples at or below the offset, up to 5
  always_comb begin
    s1  = MW'(spacing3);
    s2  = s1 << 1;
    s3  = s2 + s1;
    s4  = s1 << 2;
    s5  = s4 + s1;
    t_u = t3[MW-1:0];
    res4_next.link_ok = link3;
    res4_next.armed   = link3 && arm3;
    if (!link3 || !ok3 || t3 < 0) begin
      res4_next.mode = '0;
    end else if (t_u >= s5) begin
      res4_next.mode = MODE_W'(MODE_MAX);
    end else if (t_u >= s4) begin
      res4_next.mode = MODE_W'(4);
    end else if (t_u >= s3) begin
      res4_next.mode = MODE_W'(3);
    end else if (t_u >= s2) begin
      res4_next.mode = MODE_W'(2);
    end else if (t_u >= s1) begin
      res4_next.mode = MODE_W'(1);
    end else begin
      res4_next.mode = '0;
    end
  end

  // delay line to the divider latency
  assign dl_valid[0] = v4;
  assign dl_res[0]   = res4;

  for (genvar i = 0; i < EXTRA; i++) begin : g_delay
    always_ff @(posedge clk) begin
      if (rst) begin
        dl_valid[i+1] <= 1'b0;
      end else begin
        dl_valid[i+1] <= dl_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      dl_res[i+1] <= dl_res[i];
    end
  end

  assign out_valid = dl_valid[EXTRA];
  assign res       = dl_res[EXTRA];

endmodule
